[hdl/psc_pkg.sv]
package psc_pkg;

  // default depth of the equalization table
  localparam int unsigned CDF_DEPTH_DEF = 256;

  // one unit of colour or normalized scalar, and one half of it
  localparam logic [16:0] UNIT = 17'h10000;
  localparam logic [16:0] HALF = 17'h08000;

  // quotient bits of the window normalization, one per divider stage
  localparam int unsigned DIV_STEPS = 16;

  typedef enum logic [2:0] {
    MODE_RGB       = 3'd0,
    MODE_LABEL     = 3'd1,
    MODE_FIXED     = 3'd2,
    MODE_INTENSITY = 3'd3,
    MODE_Z         = 3'd4
  } color_mode_e;

  typedef enum logic [2:0] {
    REG_COLOR_MODE      = 3'd0,
    REG_HIGHLIGHT_NOISE = 3'd1,
    REG_EQUALIZE_ENABLE = 3'd2,
    REG_SCALAR_MIN      = 3'd3,
    REG_SCALAR_MAX      = 3'd4,
    REG_FIXED_RGB       = 3'd5,
    REG_NOISE_RGB       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic               operation;
    logic        [16:0] red_in;
    logic        [16:0] green_in;
    logic        [16:0] blue_in;
    logic signed [31:0] intensity;
    logic signed [31:0] z_position;
    logic        [16:0] noise_level;
    logic        [7:0]  cdf_index;
    logic        [16:0] cdf_value;
  } in_item_t;

  typedef struct packed {
    logic [16:0] red_out;
    logic [16:0] green_out;
    logic [16:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
  } rgb_t;

  // control and side data that travels with every request
  typedef struct packed {
    logic        valid;
    logic        op;
    logic [7:0]  cidx;
    logic [16:0] cval;
    logic        use_map;
    logic        eq;
    logic        zero;
    logic        full;
    logic        empty;
    rgb_t        direct;
  } ctl_t;

  function automatic logic [16:0] clamp_unit(input logic [16:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  function automatic rgb_t unpack_rgb(input logic [50:0] packed_rgb);
    rgb_t c;
    c.r = clamp_unit(packed_rgb[50:34]);
    c.g = clamp_unit(packed_rgb[33:17]);
    c.b = clamp_unit(packed_rgb[16:0]);
    return c;
  endfunction

  // turbo polynomial coefficients scaled by 2^24, per channel and power
  function automatic logic signed [33:0] turbo_coef(input logic [1:0] ch, input logic [2:0] k);
    logic signed [33:0] c;
    unique case ({ch, k})
      {2'd0, 3'd0}: c = 34'sd2277027;
      {2'd0, 3'd1}: c = 34'sd77433439;
      {2'd0, 3'd2}: c = -34'sd715721447;
      {2'd0, 3'd3}: c = 34'sd2216791709;
      {2'd0, 3'd4}: c = -34'sd2565947579;
      {2'd0, 3'd5}: c = 34'sd994660394;
      {2'd1, 3'd0}: c = 34'sd1533481;
      {2'd1, 3'd1}: c = 34'sd36812373;
      {2'd1, 3'd2}: c = 34'sd81251496;
      {2'd1, 3'd3}: c = -34'sd237985368;
      {2'd1, 3'd4}: c = 34'sd71761162;
      {2'd1, 3'd5}: c = 34'sd47472241;
      {2'd2, 3'd0}: c = 34'sd1789681;
      {2'd2, 3'd1}: c = 34'sd212096660;
      {2'd2, 3'd2}: c = -34'sd1016398111;
      {2'd2, 3'd3}: c = 34'sd1851579992;
      {2'd2, 3'd4}: c = -34'sd1508323881;
      {2'd2, 3'd5}: c = 34'sd458827493;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

[hdl/psc_ram.sv]
module psc_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_b_i,
  output logic [WIDTH-1:0]               rdata_a_o,
  output logic [WIDTH-1:0]               rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[hdl/point_scalar_colourizer.sv]
// Point colourizer: while not stalled, takes one request per clock and returns its colour, one
// result per clock sustained. Colour requests pass through a 16-stage restoring divider for
// the window normalization, a two-port read of the equalization table, four power stages
// and the turbo coefficient multiply and adder tree; table writes travel down the same
// pipeline and land in the table at the read stage, so reads see writes in request order.
// Table writes give no result. The table holds garbage after reset until written. The
// whole pipeline advances whenever the output register is empty or being taken.
module point_scalar_colourizer import psc_pkg::*; #(
  parameter int unsigned CDF_DEPTH = CDF_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(CDF_DEPTH);
  localparam int unsigned EW = ((AW > 8) ? AW : 8) + 1;
  localparam int unsigned SW = 17 + AW;

  // configuration registers
  logic [2:0]         color_mode_q;
  logic               highlight_q;
  logic               equalize_q;
  logic signed [31:0] smin_q;
  logic signed [31:0] smax_q;
  logic [50:0]        fixed_q;
  logic [50:0]        noise_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= MODE_RGB;
      highlight_q  <= 1'b0;
      equalize_q   <= 1'b0;
      smin_q       <= '0;
      smax_q       <= 32'sd65536;
      fixed_q      <= '0;
      noise_q      <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[5:3]))
        REG_COLOR_MODE:      color_mode_q <= pwdata[2:0];
        REG_HIGHLIGHT_NOISE: highlight_q  <= pwdata[0];
        REG_EQUALIZE_ENABLE: equalize_q   <= pwdata[0];
        REG_SCALAR_MIN:      smin_q       <= pwdata[31:0];
        REG_SCALAR_MAX:      smax_q       <= pwdata[31:0];
        REG_FIXED_RGB:       fixed_q      <= pwdata[50:0];
        REG_NOISE_RGB:       noise_q      <= pwdata[50:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx_e'(paddr[5:3]))
      REG_COLOR_MODE:      prdata = 64'(color_mode_q);
      REG_HIGHLIGHT_NOISE: prdata = 64'(highlight_q);
      REG_EQUALIZE_ENABLE: prdata = 64'(equalize_q);
      REG_SCALAR_MIN:      prdata = 64'(unsigned'(smin_q));
      REG_SCALAR_MAX:      prdata = 64'(unsigned'(smax_q));
      REG_FIXED_RGB:       prdata = 64'(fixed_q);
      REG_NOISE_RGB:       prdata = 64'(noise_q);
      default:             prdata = '0;
    endcase
  end

  // pipeline advance
  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // entry: colour selection and window difference
  logic signed [31:0] scalar;
  logic signed [32:0] sdiff;
  logic signed [32:0] srange;
  logic               noisy;
  ctl_t               ctl_in;

  always_comb begin
    scalar = (color_mode_q == MODE_INTENSITY) ? in_item_i.intensity : in_item_i.z_position;
    sdiff  = {scalar[31], scalar} - {smin_q[31], smin_q};
    srange = {smax_q[31], smax_q} - {smin_q[31], smin_q};
    noisy  = highlight_q && (in_item_i.noise_level > HALF);

    ctl_in.valid   = in_valid_i;
    ctl_in.op      = in_item_i.operation;
    ctl_in.cidx    = in_item_i.cdf_index;
    ctl_in.cval    = in_item_i.cdf_value;
    ctl_in.use_map = !noisy && (color_mode_q == MODE_INTENSITY || color_mode_q == MODE_Z);
    ctl_in.eq      = (color_mode_q == MODE_INTENSITY) && equalize_q;
    ctl_in.zero    = sdiff <= 33'sd0;
    ctl_in.full    = sdiff >= srange;
    ctl_in.empty   = !(smin_q < smax_q);
    priority if (noisy) begin
      ctl_in.direct = unpack_rgb(noise_q);
    end else if (color_mode_q == MODE_FIXED) begin
      ctl_in.direct = unpack_rgb(fixed_q);
    end else begin
      ctl_in.direct.r = clamp_unit(in_item_i.red_in);
      ctl_in.direct.g = clamp_unit(in_item_i.green_in);
      ctl_in.direct.b = clamp_unit(in_item_i.blue_in);
    end
  end

  // divider stages, one quotient bit each
  ctl_t        ctl_d_q [DIV_STEPS+1];
  logic [32:0] rem_q   [DIV_STEPS+1];
  logic [32:0] div_q   [DIV_STEPS+1];
  logic [15:0] quo_q   [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q[0] <= '0;
    end else if (en) begin
      ctl_d_q[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= unsigned'(sdiff);
      div_q[0] <= unsigned'(srange);
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [33:0] sh;
    logic        ge;

    assign sh = {rem_q[i], 1'b0};
    assign ge = sh >= {1'b0, div_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_d_q[i+1] <= '0;
      end else if (en) begin
        ctl_d_q[i+1] <= ctl_d_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i+1] <= ge ? 33'(sh - {1'b0, div_q[i]}) : sh[32:0];
        div_q[i+1] <= div_q[i];
        quo_q[i+1] <= {quo_q[i][14:0], ge};
      end
    end
  end

  // normalized scalar
  ctl_t        ctl_t_q;
  logic [16:0] t_q;
  logic [16:0] t_d;
  ctl_t        ctl_last;

  assign ctl_last = ctl_d_q[DIV_STEPS];

  always_comb begin
    priority if (ctl_last.empty) begin
      t_d = HALF;
    end else if (ctl_last.zero) begin
      t_d = '0;
    end else if (ctl_last.full) begin
      t_d = UNIT;
    end else begin
      t_d = {1'b0, quo_q[DIV_STEPS]};
    end
  end

  // table sample position
  ctl_t          ctl_s_q;
  logic [16:0]   t_s_q;
  logic [SW-1:0] s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_t_q <= '0;
      ctl_s_q <= '0;
    end else if (en) begin
      ctl_t_q <= ctl_last;
      ctl_s_q <= ctl_t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= t_d;
      t_s_q <= t_q;
      s_q   <= SW'(t_q) * SW'(CDF_DEPTH - 1);
    end
  end

  // table read and write at the same stage
  logic [AW:0]    lower_w;
  logic [AW:0]    lower_c;
  logic [AW:0]    upper_c;
  logic [EW-1:0]  idx_ext;
  logic           tbl_we;
  logic [16:0]    rd_lo;
  logic [16:0]    rd_hi;

  always_comb begin
    lower_w = s_q[SW-1:16];
    lower_c = (lower_w > (AW+1)'(CDF_DEPTH - 1)) ? (AW+1)'(CDF_DEPTH - 1) : lower_w;
    upper_c = (lower_c == (AW+1)'(CDF_DEPTH - 1)) ? lower_c : lower_c + 1'b1;
    idx_ext = EW'(ctl_s_q.cidx);
    tbl_we  = en && ctl_s_q.valid && ctl_s_q.op && (idx_ext < EW'(CDF_DEPTH));
  end

  psc_ram #(
    .WIDTH (17),
    .DEPTH (CDF_DEPTH)
  ) u_cdf_ram (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (idx_ext[AW-1:0]),
    .wdata_i   (ctl_s_q.cval),
    .re_i      (en),
    .raddr_a_i (lower_c[AW-1:0]),
    .raddr_b_i (upper_c[AW-1:0]),
    .rdata_a_o (rd_lo),
    .rdata_b_o (rd_hi)
  );

  ctl_t        ctl_r_q;
  logic [16:0] t_r_q;
  logic [15:0] f_r_q;

  // interpolation products
  ctl_t        ctl_m_q;
  logic [16:0] t_m_q;
  logic [33:0] pl_q;
  logic [33:0] ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_r_q <= '0;
      ctl_m_q <= '0;
    end else if (en) begin
      ctl_r_q <= ctl_s_q;
      ctl_m_q <= ctl_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_r_q <= t_s_q;
      f_r_q <= s_q[15:0];
      t_m_q <= t_r_q;
      pl_q  <= 34'(rd_lo) * 34'(UNIT - {1'b0, f_r_q});
      ph_q  <= 34'(rd_hi) * 34'(f_r_q);
    end
  end

  // map input, then successive powers
  logic [34:0] isum;
  logic [16:0] x_d;

  always_comb begin
    isum = {1'b0, pl_q} + {1'b0, ph_q};
    x_d  = (isum[34:16] > 19'(UNIT)) ? UNIT : isum[32:16];
    if (!ctl_m_q.eq) begin
      x_d = t_m_q;
    end
  end

  ctl_t        ctl_p_q [1:5];
  logic [16:0] pw_q    [1:5][1:5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p_q[1] <= '0;
    end else if (en) begin
      ctl_p_q[1] <= ctl_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q[1][1] <= x_d;
    end
  end

  for (genvar j = 2; j <= 5; j++) begin : g_pow
    logic [33:0] prod;

    assign prod = 34'(pw_q[j-1][j-1]) * 34'(pw_q[j-1][1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_p_q[j] <= '0;
      end else if (en) begin
        ctl_p_q[j] <= ctl_p_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 1; k < j; k++) begin
          pw_q[j][k] <= pw_q[j-1][k];
        end
        pw_q[j][j] <= prod[32:16];
      end
    end
  end

  // coefficient products
  ctl_t               ctl_c_q;
  logic signed [51:0] cp_q [3][6];
  logic        [16:0] pk   [6];

  always_comb begin
    pk[0] = UNIT;
    for (int k = 1; k < 6; k++) begin
      pk[k] = pw_q[5][k];
    end
  end

  // adder tree
  ctl_t               ctl_a_q;
  logic signed [52:0] pair_q [3][3];
  ctl_t               ctl_b_q;
  logic signed [54:0] tot_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en) begin
      ctl_c_q <= ctl_p_q[5];
      ctl_a_q <= ctl_c_q;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 6; k++) begin
          cp_q[ch][k] <= 52'(turbo_coef(2'(ch), 3'(k))) * 52'($signed({1'b0, pk[k]}));
        end
        for (int m = 0; m < 3; m++) begin
          pair_q[ch][m] <= 53'(cp_q[ch][2*m]) + 53'(cp_q[ch][2*m+1]);
        end
        tot_q[ch] <= 55'(pair_q[ch][0]) + 55'(pair_q[ch][1]) + 55'(pair_q[ch][2]);
      end
    end
  end

  // channel clamp and final colour select
  logic [16:0] chan [3];
  logic [30:0] shv  [3];
  out_item_t   out_d;
  out_item_t   out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      shv[ch] = tot_q[ch][54:24];
      if (tot_q[ch] <= 55'sd0) begin
        chan[ch] = '0;
      end else if (shv[ch] > 31'(UNIT)) begin
        chan[ch] = UNIT;
      end else begin
        chan[ch] = shv[ch][16:0];
      end
    end
    if (ctl_b_q.use_map) begin
      out_d.red_out   = chan[0];
      out_d.green_out = chan[1];
      out_d.blue_out  = chan[2];
    end else begin
      out_d.red_out   = ctl_b_q.direct.r;
      out_d.green_out = ctl_b_q.direct.g;
      out_d.blue_out  = ctl_b_q.direct.b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_b_q.valid && !ctl_b_q.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hdl/psc_checker.sv]
module psc_checker import psc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // every channel is clamped to one unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.red_out <= UNIT) && (out_item_o.green_out <= UNIT)
                    && (out_item_o.blue_out <= UNIT))
    else $error("channel above one unit");

  // input side only stalls when a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input stalled without a held result");

endmodule

bind point_scalar_colourizer psc_checker u_psc_checker (.*);
